/* sv/mcs_pkg.sv */
package mcs_pkg;

    localparam int MaxWindowDefault  = 10;
    localparam int ScaleFracDefault  = 12;
    localparam int NumAxes           = 3;
    localparam int CfgIdxWidth       = 3;
    localparam int CfgDataWidth      = 16;

    typedef enum logic [1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_NOT_READY = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_SCALE_X  = 3'd3,
        REG_SCALE_Y  = 3'd4,
        REG_SCALE_Z  = 3'd5,
        REG_MODE     = 3'd6,
        REG_WINDOW   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAL_MUL,
        ST_CAL_SAT,
        ST_WRITE,
        ST_SCAN,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // capture input word
        logic cal_mul;      // multiply current axis
        logic cal_sat;      // shift/saturate current axis
        logic hist_write;   // write current axis into ring
        logic scan_clear;   // clear accumulators
        logic scan_step;    // visit one ring entry
        logic div_start;    // set up divider
        logic div_step;     // one divider iteration
        logic div_store;    // store quotient
        logic slot_advance; // bump write slot
        logic out_load;     // present result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic invalid;      // item returns a status code only
        logic smooth_on;
        logic scan_last;
        logic div_last;
        logic axis_last;
    } stat_t;

endpackage

/* sv/mcs_ctrl.sv */
module mcs_ctrl
    import mcs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    output logic  m_valid,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_CAL_MUL;
            ST_CAL_MUL:   state_next = stat.invalid ? ST_OUT : ST_CAL_SAT;
            ST_CAL_SAT:   state_next = stat.smooth_on ? ST_WRITE
                                     : (stat.axis_last ? ST_OUT : ST_CAL_MUL);
            ST_WRITE:     state_next = ST_SCAN;
            ST_SCAN:      if (stat.scan_last) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:   if (stat.div_last) state_next = ST_DIV_STORE;
            ST_DIV_STORE: state_next = stat.axis_last ? ST_OUT : ST_CAL_MUL;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_CAL_MUL:   cmd.cal_mul = 1'b1;
            ST_CAL_SAT:   cmd.cal_sat = 1'b1;
            ST_WRITE: begin
                cmd.hist_write = 1'b1;
                cmd.scan_clear = 1'b1;
            end
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_RUN:   cmd.div_step = 1'b1;
            ST_DIV_STORE: begin
                cmd.div_store    = 1'b1;
                cmd.slot_advance = stat.axis_last;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_CAL_MUL)
        else $error("accepted word not processed");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("result dropped");

endmodule

/* sv/mcs_datapath.sv */
module mcs_datapath
    import mcs_pkg::*;
#(
    parameter int MAX_WINDOW          = MaxWindowDefault,
    parameter int SCALE_FRACTION_BITS = ScaleFracDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    s_data_ready,
    input  logic                    s_overflow,
    input  logic signed [15:0]      s_raw_x,
    input  logic signed [15:0]      s_raw_y,
    input  logic signed [15:0]      s_raw_z,
    output logic [1:0]              m_result_status,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic signed [15:0]      m_out_z,
    input  cmd_t                    cmd,
    output stat_t                   stat
);

    localparam int WW   = $clog2(MAX_WINDOW + 1);
    localparam int SW   = $clog2(MAX_WINDOW);
    localparam int TW   = 16 + WW;              // window total width
    localparam int QW   = TW + 1;               // dividend magnitude width
    localparam int QCW  = $clog2(QW + 1);

    // configuration
    logic signed [15:0] offset_reg [NumAxes];
    logic [15:0]        scale_reg  [NumAxes];
    logic [1:0]         mode_reg;
    logic [3:0]         window_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NumAxes; a++) begin
                offset_reg[a] <= '0;
                scale_reg[a]  <= 16'd4096;
            end
            mode_reg   <= '0;
            window_reg <= 4'd10;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_OFFSET_X: offset_reg[0] <= cfg_data;
                REG_OFFSET_Y: offset_reg[1] <= cfg_data;
                REG_OFFSET_Z: offset_reg[2] <= cfg_data;
                REG_SCALE_X:  scale_reg[0]  <= cfg_data;
                REG_SCALE_Y:  scale_reg[1]  <= cfg_data;
                REG_SCALE_Z:  scale_reg[2]  <= cfg_data;
                REG_MODE:     mode_reg      <= cfg_data[1:0];
                REG_WINDOW:   window_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective window
    logic [WW-1:0] win;
    always_comb begin
        if (window_reg == 4'd0) begin
            win = WW'(1);
        end else if ({28'd0, window_reg} > 32'(MAX_WINDOW)) begin
            win = WW'(MAX_WINDOW);
        end else begin
            win = WW'(window_reg);
        end
    end
    logic trimmed;
    assign trimmed = mode_reg[1] && (win >= WW'(3));

    // captured word
    logic               rdy_reg, ovf_reg;
    logic signed [15:0] raw_reg [NumAxes];
    logic [1:0]         axis_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rdy_reg    <= s_data_ready;
            ovf_reg    <= s_overflow;
            raw_reg[0] <= s_raw_x;
            raw_reg[1] <= s_raw_y;
            raw_reg[2] <= s_raw_z;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.load) begin
            axis_reg <= '0;
        end else if ((cmd.cal_sat && !stat.smooth_on) || cmd.div_store) begin
            axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
        end
    end

    assign stat.invalid   = ovf_reg || !rdy_reg;
    assign stat.smooth_on = mode_reg != 2'd0;
    assign stat.axis_last = axis_reg == 2'd2;

    // calibration: multiply, then truncate toward zero and saturate
    logic signed [16:0] diff;
    logic signed [33:0] prod_reg;
    assign diff = 17'(raw_reg[axis_reg]) - 17'(offset_reg[axis_reg]);
    always_ff @(posedge aclk) begin
        if (cmd.cal_mul) begin
            prod_reg <= 34'(diff) * $signed({18'd0, scale_reg[axis_reg]});
        end
    end

    logic signed [33:0] prod_adj, q;
    logic signed [15:0] cal_sat_v;
    always_comb begin
        prod_adj = prod_reg;
        if (prod_reg < 0) begin
            prod_adj = prod_reg + 34'((64'd1 << SCALE_FRACTION_BITS) - 64'd1);
        end
        q = prod_adj >>> SCALE_FRACTION_BITS;
        if (q > 34'sd32767) begin
            cal_sat_v = 16'sd32767;
        end else if (q < -34'sd32768) begin
            cal_sat_v = -16'sd32768;
        end else begin
            cal_sat_v = q[15:0];
        end
    end

    logic signed [QW-1:0] quot;
    logic signed [15:0]   quot_sat;
    logic signed [15:0]   cal_reg;
    logic signed [15:0]   res_reg [NumAxes];
    always_ff @(posedge aclk) begin
        if (cmd.cal_sat) begin
            cal_reg <= cal_sat_v;
            if (!stat.smooth_on) begin
                res_reg[axis_reg] <= cal_sat_v;
            end
        end else if (cmd.div_store) begin
            res_reg[axis_reg] <= quot_sat;
        end
    end

    // history ring, one lane per axis; cleared at reset
    logic signed [15:0] hist_reg [MAX_WINDOW][NumAxes];
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      slot_eff;
    assign slot_eff = ({1'b0, slot_reg} >= {1'b0, win[SW-1:0]} || win > WW'(slot_reg))
                      ? ((WW'(slot_reg) >= win) ? '0 : slot_reg) : slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                for (int a = 0; a < NumAxes; a++) begin
                    hist_reg[i][a] <= '0;
                end
            end
            slot_reg <= '0;
        end else begin
            if (cmd.hist_write) begin
                hist_reg[slot_eff][axis_reg] <= cal_reg;
                slot_reg <= slot_eff;
            end
            if (cmd.slot_advance) begin
                slot_reg <= (slot_reg == SW'(MAX_WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
        end
    end

    // scan: one entry a cycle
    logic [SW-1:0]       scan_reg;
    logic signed [TW-1:0] total_reg;
    logic signed [15:0]  hi_reg, lo_reg, v;
    assign v = hist_reg[scan_reg][axis_reg];
    assign stat.scan_last = WW'(scan_reg) == win - WW'(1);
    always_ff @(posedge aclk) begin
        if (cmd.scan_clear) begin
            scan_reg  <= '0;
            total_reg <= '0;
            hi_reg    <= 16'sh8000;
            lo_reg    <= 16'sh7fff;
        end else if (cmd.scan_step) begin
            scan_reg  <= scan_reg + 1'b1;
            total_reg <= total_reg + TW'(v);
            if (v > hi_reg) hi_reg <= v;
            if (v < lo_reg) lo_reg <= v;
        end
    end

    // restoring divider on magnitudes, one bit a cycle
    logic signed [QW-1:0] dividend;
    logic [QW-1:0]        num_reg, rem_reg;
    logic [WW-1:0]        den_reg;
    logic                 neg_reg;
    logic [QCW-1:0]       cnt_reg;
    logic [QW:0]          rem_sh;
    assign dividend = trimmed ? (QW'(total_reg) - QW'(hi_reg) - QW'(lo_reg))
                              : QW'(total_reg);
    assign rem_sh = {rem_reg, num_reg[QW-1]};
    assign stat.div_last = cnt_reg == QCW'(QW - 1);
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= dividend[QW-1];
            num_reg <= dividend[QW-1] ? QW'(-dividend) : QW'(dividend);
            den_reg <= trimmed ? win - WW'(2) : win;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (rem_sh >= (QW + 1)'(den_reg)) begin
                rem_reg <= QW'(rem_sh - (QW + 1)'(den_reg));
                num_reg <= {num_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= QW'(rem_sh);
                num_reg <= {num_reg[QW-2:0], 1'b0};
            end
        end
    end

    assign quot = neg_reg ? -$signed(num_reg) : $signed(num_reg);
    always_comb begin
        if (quot > QW'(32767)) begin
            quot_sat = 16'sd32767;
        end else if (quot < -$signed(QW'(32768))) begin
            quot_sat = -16'sd32768;
        end else begin
            quot_sat = quot[15:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (ovf_reg) begin
                m_result_status <= STATUS_OVERFLOW;
            end else if (!rdy_reg) begin
                m_result_status <= STATUS_NOT_READY;
            end else begin
                m_result_status <= STATUS_VALID;
            end
            m_out_x <= stat.invalid ? '0 : res_reg[0];
            m_out_y <= stat.invalid ? '0 : res_reg[1];
            m_out_z <= stat.invalid ? '0 : res_reg[2];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> WW'(scan_reg) < win)
        else $error("scan beyond window");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> den_reg != '0)
        else $error("divider with zero divisor");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hist_write |-> WW'(slot_eff) < win)
        else $error("ring write outside window");

endmodule

/* sv/magnetometer_calibrate_smooth.sv */
// Calibrates one magnetometer sample per word: each axis is corrected as
// (raw - offset) * scale (unsigned, SCALE_FRACTION_BITS fraction bits),
// truncated and saturated to 16 bits, then optionally averaged over a ring
// of up to MAX_WINDOW entries (plain, or without largest and smallest).
// One word is processed at a time. A word with overflow or without ready
// skips from the multiply step to the output with a status code only.
// Otherwise each axis is multiplied and saturated; with smoothing it is
// then written into the ring, its W entries are scanned one a cycle, and
// the bit-serial divider is set up, run and its quotient stored.
// Write configuration only while no word is in flight.
module magnetometer_calibrate_smooth
    import mcs_pkg::*;
#(
    parameter int MAX_WINDOW          = MaxWindowDefault,
    parameter int SCALE_FRACTION_BITS = ScaleFracDefault
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_data_ready,
    input  logic                    s_overflow,
    input  logic signed [15:0]      s_raw_x,
    input  logic signed [15:0]      s_raw_y,
    input  logic signed [15:0]      s_raw_z,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_result_status,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic signed [15:0]      m_out_z
);

    cmd_t  cmd;
    stat_t stat;

    mcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mcs_datapath #(
        .MAX_WINDOW          (MAX_WINDOW),
        .SCALE_FRACTION_BITS (SCALE_FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_data_ready    (s_data_ready),
        .s_overflow      (s_overflow),
        .s_raw_x         (s_raw_x),
        .s_raw_y         (s_raw_y),
        .s_raw_z         (s_raw_z),
        .m_result_status (m_result_status),
        .m_out_x         (m_out_x),
        .m_out_y         (m_out_y),
        .m_out_z         (m_out_z),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
